/* rtl/core/fwbt_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the fixed-weight basis table block.
package fwbt_pkg;

   localparam int DEF_MAX_SITES   = 16;
   localparam int DEF_TABLE_DEPTH = 16384;

   localparam int FUNC_W    = 2;
   localparam int OPERAND_W = 16;
   localparam int VALUE_W   = 16;
   localparam int STATUS_W  = 2;
   localparam int CFG_W     = 5;
   localparam int CSR_IDX_W = 1;

   // Function codes carried in a request beat.
   localparam logic [FUNC_W-1:0] FUNC_BUILD    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WORD_AT  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_INDEX_OF = 2'd2;

   // Status codes carried in a response beat.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_BUILT = 2'd2;

   // Configuration register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_SITES     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_PARTICLES = 1'b1;
   localparam logic [CFG_W-1:0]     NUM_SITES_RST     = 5'd16;
   localparam logic [CFG_W-1:0]     NUM_PARTICLES_RST = 5'd8;

   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      logic [OPERAND_W-1:0] operand;
   } req_payload_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic [STATUS_W-1:0] status;
   } rsp_payload_type;

endpackage

/* rtl/core/fwbt_word_ram.sv */
`timescale 1ns / 1ps
// Single-port-write, single-port-read word store with a registered read.
module fwbt_word_ram
   import fwbt_pkg::*;
#(
   parameter int DEPTH = DEF_TABLE_DEPTH,
   parameter int WIDTH = DEF_MAX_SITES,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/fixed_weight_basis_table_core.sv */
`timescale 1ns / 1ps
// Top level of the fixed-weight basis table: sequencer, counters and table store.
//
// A request beat is taken when start is high and busy is low. func selects a
// build of the table (every word of num_sites bits with num_particles ones, in
// increasing order), a lookup of the word at an index, or a binary search for
// the index of a word. Each request yields exactly one response beat, shown on
// rsp_data for one cycle with rsp_valid high; the receiver cannot hold it off.
// busy falls in the same cycle the response is shown, so the next request may
// be taken then.
// Sequence: unused func codes, lookups before a build and word lookups past the
// count answer from S_IDLE in the cycle after the request. Any other word lookup
// passes S_WORD_READ and S_WORD_OUT. A search repeats S_SPLIT, S_PROBE_READ and
// S_PROBE_CMP once per probe, and a word that is absent ends in S_SPLIT. A build
// visits one candidate word per cycle, every word below 2^num_sites (num_sites
// capped at MAX_SITES), or fewer when the table fills.
// Reset clears the table's count and built flag and restores num_sites to 16
// and num_particles to 8. Registers must be written through csr_* only while
// idle; the block itself does not enforce this.
module fixed_weight_basis_table_core
   import fwbt_pkg::*;
#(
   parameter int MAX_SITES   = DEF_MAX_SITES,
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_payload_type      req_data,
   output logic                 rsp_valid,
   output rsp_payload_type      rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int CW   = $clog2(TABLE_DEPTH + 1);
   localparam int SW   = MAX_SITES + 1;
   localparam int PCW  = $clog2(MAX_SITES + 1);
   localparam int IXW  = (CW > OPERAND_W) ? CW : OPERAND_W;
   localparam int CMPW = (MAX_SITES > OPERAND_W) ? MAX_SITES : OPERAND_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_BUILD,
      S_WORD_READ,
      S_WORD_OUT,
      S_SPLIT,
      S_PROBE_READ,
      S_PROBE_CMP
   } state_type;

   function automatic logic [PCW-1:0] ones_in(input logic [MAX_SITES-1:0] w);
      logic [PCW-1:0] n;
      n = '0;
      for (int i = 0; i < MAX_SITES; i++) begin
         n = n + PCW'(w[i]);
      end
      return n;
   endfunction

   state_type            state_ff, state_in;
   logic [CFG_W-1:0]     num_sites_ff, num_sites_in;
   logic [CFG_W-1:0]     num_particles_ff, num_particles_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 built_ff, built_in;
   logic [SW-1:0]        walk_ff, walk_in;
   logic [SW-1:0]        limit_ff, limit_in;
   logic [CW-1:0]        lo_ff, lo_in;
   logic [CW-1:0]        hix_ff, hix_in;
   logic [CW-1:0]        mid_ff, mid_in;
   logic [AW-1:0]        rd_addr_ff, rd_addr_in;
   logic [OPERAND_W-1:0] op_ff, op_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_data_ff, rsp_data_in;

   logic [CFG_W-1:0]     sites_eff;
   logic [PCW-1:0]       walk_ones;
   logic                 walk_match;
   logic [CW:0]          mid_sum;
   logic [CW-1:0]        mid_calc;
   logic [IXW-1:0]       op_ext;
   logic [IXW-1:0]       count_ext;
   logic [CMPW-1:0]      probe_ext;
   logic [CMPW-1:0]      key_ext;
   logic                 wr_en;
   logic [MAX_SITES-1:0] rd_data;

   fwbt_word_ram #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (MAX_SITES)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (walk_ff[MAX_SITES-1:0]),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   assign sites_eff  = (num_sites_ff > CFG_W'(MAX_SITES)) ? CFG_W'(MAX_SITES) : num_sites_ff;
   assign walk_ones  = ones_in(walk_ff[MAX_SITES-1:0]);
   assign walk_match = ((CFG_W + 1)'(walk_ones) == {1'b0, num_particles_ff});
   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hix_ff};
   assign mid_calc   = mid_sum[CW:1];
   assign op_ext     = IXW'(req_data.operand);
   assign count_ext  = IXW'(count_ff);
   assign probe_ext  = CMPW'(rd_data);
   assign key_ext    = CMPW'(op_ff);

   always_comb begin
      state_in         = state_ff;
      num_sites_in     = num_sites_ff;
      num_particles_in = num_particles_ff;
      count_in         = count_ff;
      built_in         = built_ff;
      walk_in          = walk_ff;
      limit_in         = limit_ff;
      lo_in            = lo_ff;
      hix_in           = hix_ff;
      mid_in           = mid_ff;
      rd_addr_in       = rd_addr_ff;
      op_in            = op_ff;
      rsp_valid_in     = 1'b0;
      rsp_data_in      = rsp_data_ff;
      wr_en            = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_SITES:     num_sites_in     = csr_wdata;
            CSR_NUM_PARTICLES: num_particles_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in = req_data.operand;
               unique case (req_data.func)
                  FUNC_BUILD: begin
                     walk_in  = '0;
                     count_in = '0;
                     limit_in = SW'(1) << sites_eff;
                     state_in = S_BUILD;
                  end
                  FUNC_WORD_AT: begin
                     if (!built_ff) begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.value  = '0;
                        rsp_data_in.status = ST_NOT_BUILT;
                     end else if (op_ext < count_ext) begin
                        rd_addr_in = op_ext[AW-1:0];
                        state_in   = S_WORD_READ;
                     end else begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.value  = '0;
                        rsp_data_in.status = ST_MISS;
                     end
                  end
                  FUNC_INDEX_OF: begin
                     if (!built_ff) begin
                        rsp_valid_in       = 1'b1;
                        rsp_data_in.value  = '0;
                        rsp_data_in.status = ST_NOT_BUILT;
                     end else begin
                        lo_in    = '0;
                        hix_in   = count_ff;
                        state_in = S_SPLIT;
                     end
                  end
                  default: begin
                     rsp_valid_in       = 1'b1;
                     rsp_data_in.value  = '0;
                     rsp_data_in.status = ST_MISS;
                  end
               endcase
            end
         end

         S_BUILD: begin
            // The walk ends past the last word, or at a match that finds the table full.
            if ((walk_ff == limit_ff) ||
                (walk_match && (count_ff == CW'(TABLE_DEPTH)))) begin
               built_in           = 1'b1;
               rsp_valid_in       = 1'b1;
               rsp_data_in.value  = VALUE_W'(count_ff);
               rsp_data_in.status = ST_OK;
               state_in           = S_IDLE;
            end else begin
               if (walk_match) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               walk_in = walk_ff + 1'b1;
            end
         end

         S_WORD_READ: begin
            state_in = S_WORD_OUT;
         end

         S_WORD_OUT: begin
            rsp_valid_in       = 1'b1;
            rsp_data_in.value  = VALUE_W'(rd_data);
            rsp_data_in.status = ST_OK;
            state_in           = S_IDLE;
         end

         S_SPLIT: begin
            // The search window is lo up to, but not including, hix.
            if (lo_ff >= hix_ff) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.value  = '0;
               rsp_data_in.status = ST_MISS;
               state_in           = S_IDLE;
            end else begin
               mid_in     = mid_calc;
               rd_addr_in = mid_calc[AW-1:0];
               state_in   = S_PROBE_READ;
            end
         end

         S_PROBE_READ: begin
            state_in = S_PROBE_CMP;
         end

         S_PROBE_CMP: begin
            if (probe_ext == key_ext) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.value  = VALUE_W'(mid_ff);
               rsp_data_in.status = ST_OK;
               state_in           = S_IDLE;
            end else begin
               if (key_ext > probe_ext) begin
                  lo_in = mid_ff + 1'b1;
               end else begin
                  hix_in = mid_ff;
               end
               state_in = S_SPLIT;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         num_sites_ff     <= NUM_SITES_RST;
         num_particles_ff <= NUM_PARTICLES_RST;
         count_ff         <= '0;
         built_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         num_sites_ff     <= num_sites_in;
         num_particles_ff <= num_particles_in;
         count_ff         <= count_in;
         built_ff         <= built_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      walk_ff     <= walk_in;
      limit_ff    <= limit_in;
      lo_ff       <= lo_in;
      hix_ff      <= hix_in;
      mid_ff      <= mid_in;
      rd_addr_ff  <= rd_addr_in;
      op_ff       <= op_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* dv/fwbt_table_checker.sv */
`timescale 1ns / 1ps
// Checker for the basis table core: tracks registers and table, predicts and compares responses.
module fwbt_table_checker
   import fwbt_pkg::*;
#(
   parameter int MAX_SITES   = DEF_MAX_SITES,
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  req_payload_type      req_data,
   input  logic                 rsp_valid,
   input  rsp_payload_type      rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output int                   error_count,
   output int                   pending_count,
   output int                   compared_count
);

   logic [VALUE_W-1:0] basis_mem [TABLE_DEPTH];
   int                 basis_len;
   bit                 basis_ready;
   logic [CFG_W-1:0]   sites_cfg;
   logic [CFG_W-1:0]   particles_cfg;
   rsp_payload_type    answer_q [$];
   int                 err_total;
   int                 cmp_total;

   // Walk every word of the current width in increasing order and keep the ones
   // with the requested weight, stopping when the store is full.
   function automatic void rebuild_basis();
      int n_bits;
      int word_lim;
      n_bits    = (sites_cfg > MAX_SITES) ? MAX_SITES : int'(sites_cfg);
      word_lim  = 1 << n_bits;
      basis_len = 0;
      for (int w = 0; w < word_lim; w++) begin
         if ($countones(w) == int'(particles_cfg)) begin
            if (basis_len >= TABLE_DEPTH) break;
            basis_mem[basis_len] = VALUE_W'(w);
            basis_len++;
         end
      end
      basis_ready = 1'b1;
   endfunction

   function automatic rsp_payload_type lookup_answer(req_payload_type beat);
      rsp_payload_type ans;
      int              lo;
      int              hi;
      int              mid;
      ans.value  = '0;
      ans.status = ST_OK;
      case (beat.func)
         FUNC_BUILD: begin
            rebuild_basis();
            ans.value = VALUE_W'(basis_len);
         end
         FUNC_WORD_AT: begin
            if (!basis_ready) begin
               ans.status = ST_NOT_BUILT;
            end else if (int'(beat.operand) < basis_len) begin
               ans.value = basis_mem[beat.operand];
            end else begin
               ans.status = ST_MISS;
            end
         end
         FUNC_INDEX_OF: begin
            if (!basis_ready) begin
               ans.status = ST_NOT_BUILT;
            end else begin
               ans.status = ST_MISS;
               lo = 0;
               hi = basis_len - 1;
               while (lo <= hi) begin
                  mid = lo + (hi - lo) / 2;
                  if (basis_mem[mid] == beat.operand) begin
                     ans.value  = VALUE_W'(mid);
                     ans.status = ST_OK;
                     break;
                  end else if (beat.operand > basis_mem[mid]) begin
                     lo = mid + 1;
                  end else begin
                     hi = mid - 1;
                  end
               end
            end
         end
         default: begin
            ans.status = ST_MISS;
         end
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      bit              bad;
      if (reset) begin
         basis_len     = 0;
         basis_ready   = 1'b0;
         sites_cfg     = NUM_SITES_RST;
         particles_cfg = NUM_PARTICLES_RST;
         answer_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_NUM_SITES:     sites_cfg = csr_wdata;
               CSR_NUM_PARTICLES: particles_cfg = csr_wdata;
               default: ;
            endcase
         end
         // The beat shown in this cycle belongs to an earlier request, so it is
         // checked before a request taken at this same edge is predicted.
         if (rsp_valid) begin
            if (answer_q.size() == 0) begin
               $display("%0t: response beat with nothing expected, value %h status %0d",
                        $time, rsp_data.value, rsp_data.status);
               err_total++;
            end else begin
               want = answer_q.pop_front();
               bad  = 1'b0;
               cmp_total++;
               if (rsp_data.value !== want.value) begin
                  $display("%0t: value mismatch, expected %h, actual %h",
                           $time, want.value, rsp_data.value);
                  bad = 1'b1;
               end
               if (rsp_data.status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, rsp_data.status);
                  bad = 1'b1;
               end
               if (bad) err_total++;
            end
         end
         if (start && !busy) answer_q.push_back(lookup_answer(req_data));
      end
      error_count    <= err_total;
      compared_count <= cmp_total;
      pending_count  <= answer_q.size();
   end

endmodule

/* dv/fixed_weight_basis_table_core_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the basis table core: stimulus, register writes and the verdict.
module fixed_weight_basis_table_core_tb;
   import fwbt_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int RANDOM_BEATS = 500;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 start     = 1'b0;
   logic                 busy;
   req_payload_type      req_data  = '0;
   logic                 rsp_valid;
   rsp_payload_type      rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   int chk_errors;
   int chk_pending;
   int chk_compared;

   logic [VALUE_W-1:0] last_value = '0;
   int calm_left  = 0;
   int n_builds   = 0;
   int n_lookups  = 0;
   int n_unused   = 0;
   int n_settings = 0;
   int cfg_sites;
   int cfg_particles;
   int tbl_bits;
   int tbl_ones;
   int tbl_count;

   fixed_weight_basis_table_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   fwbt_table_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .error_count    (chk_errors),
      .pending_count  (chk_pending),
      .compared_count (chk_compared)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The last response value tells the stimulus how large the current table is.
   always @(posedge clock) begin
      if (rsp_valid) last_value <= rsp_data.value;
   end

   initial begin
      #50_000_000;
      $display("%0t: run did not finish in time", $time);
      $display("FAIL fixed_weight_basis_table_core");
      $finish;
   end

   function automatic int pick_gap();
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(5, 20);
      return $urandom_range(0, 6);
   endfunction

   // A word of n_bits bits with exactly n_ones bits set, at random positions.
   function automatic logic [OPERAND_W-1:0] weight_word(int n_bits, int n_ones);
      logic [OPERAND_W-1:0] w;
      int                   placed;
      int                   b;
      w      = '0;
      placed = 0;
      while (placed < n_ones) begin
         b = $urandom_range(0, n_bits - 1);
         if (!w[b]) begin
            w[b] = 1'b1;
            placed++;
         end
      end
      return w;
   endfunction

   // Keeps start high across back-to-back beats so it never sees two updates in one step.
   task automatic send_beat(input logic [FUNC_W-1:0] f, input logic [OPERAND_W-1:0] op);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= '{func: f, operand: op};
      do @(posedge clock); while (busy);
      case (f) inside
         FUNC_BUILD:                  n_builds++;
         FUNC_WORD_AT, FUNC_INDEX_OF: n_lookups++;
         default:                     n_unused++;
      endcase
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (chk_pending != 0 || busy);
   endtask

   task automatic write_regs(input int sites, input int particles);
      csr_we    <= 1'b1;
      csr_index <= CSR_NUM_SITES;
      csr_wdata <= CFG_W'(sites);
      @(posedge clock);
      csr_index <= CSR_NUM_PARTICLES;
      csr_wdata <= CFG_W'(particles);
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_sites     = sites;
      cfg_particles = particles;
      n_settings++;
   endtask

   task automatic build_and_learn();
      send_beat(FUNC_BUILD, OPERAND_W'($urandom()));
      drain();
      tbl_count = int'(last_value);
      tbl_bits  = (cfg_sites > DEF_MAX_SITES) ? DEF_MAX_SITES : cfg_sites;
      tbl_ones  = cfg_particles;
   endtask

   task automatic send_random_lookup();
      int                   pick;
      logic [OPERAND_W-1:0] op;
      pick = $urandom_range(0, 19);
      if (pick < 8) begin
         if (tbl_count > 0 && pick < 6) op = OPERAND_W'($urandom_range(0, tbl_count - 1));
         else if (pick == 6)            op = OPERAND_W'(tbl_count + $urandom_range(0, 2));
         else                           op = OPERAND_W'($urandom());
         send_beat(FUNC_WORD_AT, op);
      end else if (pick < 17) begin
         if (tbl_ones <= tbl_bits && pick < 15) op = weight_word(tbl_bits, tbl_ones);
         else if (pick == 15) op = OPERAND_W'($urandom_range(0, (1 << tbl_bits) - 1));
         else                 op = OPERAND_W'($urandom());
         send_beat(FUNC_INDEX_OF, op);
      end else begin
         send_beat(FUNC_UNUSED, OPERAND_W'($urandom()));
      end
   endtask

   initial begin
      int random_base;
      int sites;
      int particles;
      cfg_sites     = NUM_SITES_RST;
      cfg_particles = NUM_PARTICLES_RST;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Lookups before any build, and the unused code.
      send_beat(FUNC_WORD_AT, 16'h0000);
      send_beat(FUNC_INDEX_OF, 16'h0000);
      send_beat(FUNC_UNUSED, 16'hFFFF);
      drain();

      // Table at the reset setting: sixteen sites, eight ones.
      build_and_learn();
      send_beat(FUNC_WORD_AT, 16'h0000);
      send_beat(FUNC_WORD_AT, OPERAND_W'(tbl_count - 1));
      send_beat(FUNC_WORD_AT, OPERAND_W'(tbl_count));
      send_beat(FUNC_WORD_AT, 16'hFFFF);
      send_beat(FUNC_INDEX_OF, 16'h00FF);
      send_beat(FUNC_INDEX_OF, 16'hFF00);
      send_beat(FUNC_INDEX_OF, 16'hAAAA);
      send_beat(FUNC_INDEX_OF, 16'hFFFF);
      send_beat(FUNC_INDEX_OF, 16'h0000);
      send_beat(FUNC_UNUSED, 16'h5A5A);
      drain();

      // Site count above the limit saturates; all ones gives a single word.
      write_regs(31, 16);
      build_and_learn();
      send_beat(FUNC_WORD_AT, 16'h0000);
      send_beat(FUNC_INDEX_OF, 16'hFFFF);
      send_beat(FUNC_WORD_AT, 16'h0001);
      drain();

      // Zero sites: only the empty word, kept only for zero ones.
      write_regs(0, 0);
      build_and_learn();
      send_beat(FUNC_WORD_AT, 16'h0000);
      send_beat(FUNC_INDEX_OF, 16'h0000);
      drain();
      write_regs(0, 1);
      build_and_learn();
      send_beat(FUNC_INDEX_OF, 16'h0000);
      send_beat(FUNC_WORD_AT, 16'h0000);
      drain();

      // More ones than sites leaves the table empty.
      write_regs(3, 5);
      build_and_learn();

      // New settings without a build keep the old table in use.
      write_regs(4, 2);
      build_and_learn();
      write_regs(8, 1);
      send_beat(FUNC_WORD_AT, 16'h0005);
      send_beat(FUNC_INDEX_OF, 16'h0003);

      random_base = n_builds + n_lookups;
      while (n_builds + n_lookups - random_base < RANDOM_BEATS) begin
         drain();
         sites = $urandom_range(0, 19);
         if (sites == 0)     sites = 0;
         else if (sites < 3) sites = $urandom_range(11, 12);
         else                sites = $urandom_range(1, 10);
         if ($urandom_range(0, 7) == 0) particles = $urandom_range(sites + 1, 31);
         else                           particles = $urandom_range(0, sites);
         write_regs(sites, particles);
         if ($urandom_range(0, 5) != 0) begin
            if ($urandom_range(0, 3) == 0) send_beat(FUNC_BUILD, OPERAND_W'($urandom()));
            build_and_learn();
         end
         repeat ($urandom_range(8, 30)) send_random_lookup();
      end
      drain();
      repeat (20) @(posedge clock);

      if (chk_pending != 0) $display("%0t: %0d expected responses never arrived",
                                     $time, chk_pending);
      $display("Covered %0d builds, %0d lookups and %0d unused-code beats over %0d settings.",
               n_builds, n_lookups, n_unused, n_settings);
      $display("%0d response beats were compared with the predicted table.", chk_compared);
      if (chk_errors == 0 && chk_pending == 0) begin
         $display("PASS fixed_weight_basis_table_core");
      end else begin
         $display("FAIL fixed_weight_basis_table_core");
      end
      $finish;
   end

endmodule

/* fixed_weight_basis_table_core.f */
rtl/core/fwbt_pkg.sv
rtl/core/fwbt_word_ram.sv
rtl/core/fixed_weight_basis_table_core.sv
dv/fwbt_table_checker.sv
dv/fixed_weight_basis_table_core_tb.sv
